// File: hdl/alignment_column_variant_caller_defines.svh
// Assertion macros used by the alignment column variant caller checker.
`ifndef ALIGNMENT_COLUMN_VARIANT_CALLER_DEFINES_SVH
`define ALIGNMENT_COLUMN_VARIANT_CALLER_DEFINES_SVH

// Clocked assertion, muted while reset is held.
`define ACV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ACV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/acv_pkg.sv
// Shared types, constants and helpers of the alignment column variant caller.
`timescale 1ns / 1ps
package acv_pkg;

  localparam int unsigned POS_WIDTH_DEFAULT = 32;
  localparam int unsigned OUT_WIDTH         = 32;
  localparam int unsigned CFG_WIDTH         = 32;
  localparam int unsigned MAX_RECORDS       = 3;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam logic [7:0] CHAR_GAP = 8'd45;  // '-'
  localparam logic [7:0] CHAR_N   = 8'd78;  // 'N'
  localparam logic [7:0] CHAR_LA  = 8'd97;  // 'a'
  localparam logic [7:0] CHAR_LZ  = 8'd122; // 'z'
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam logic [1:0] KIND_SNP = 2'd0;
  localparam logic [1:0] KIND_INS = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic REG_TARGET_BEGIN = 1'b0;
  localparam logic REG_QUERY_BEGIN  = 1'b1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [OUT_WIDTH-1:0] target_first;
    logic [OUT_WIDTH-1:0] target_last;
    logic [OUT_WIDTH-1:0] query_first;
    logic [OUT_WIDTH-1:0] query_last;
  } rec_t;

  // All records caused by one column, in delivery order.
  typedef struct packed {
    logic [1:0]                 count;
    rec_t [MAX_RECORDS-1:0]     slots;
  } bundle_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  function automatic rec_t mk_rec(input logic [1:0] kind,
                                  input logic [OUT_WIDTH-1:0] tf,
                                  input logic [OUT_WIDTH-1:0] tl,
                                  input logic [OUT_WIDTH-1:0] qf,
                                  input logic [OUT_WIDTH-1:0] ql);
    rec_t r;
    r.kind         = kind;
    r.target_first = tf;
    r.target_last  = tl;
    r.query_first  = qf;
    r.query_last   = ql;
    return r;
  endfunction

endpackage

// File: hdl/acv_front.sv
// Front end: column intake, position tracking and record classification.
`timescale 1ns / 1ps
module acv_front #(
  parameter int unsigned POSITION_WIDTH = acv_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [acv_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     target_char_i,
  input  logic [7:0]                     query_char_i,
  input  logic                           end_of_alignment_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output acv_pkg::bundle_t               bundle_o
);
  import acv_pkg::*;

  localparam int unsigned NUM_CAND = 5;
  localparam int unsigned PW       = POSITION_WIDTH;

  typedef logic [PW-1:0] pos_t;

  function automatic pos_t pos_inc(input pos_t p);
    return (p == {PW{1'b1}}) ? p : p + pos_t'(1);
  endfunction

  function automatic pos_t pos_dec(input pos_t p);
    return p - pos_t'(1);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input pos_t p);
    return OUT_WIDTH'(p);
  endfunction

  logic [CFG_WIDTH-1:0] tbeg_q, qbeg_q;
  pos_t                 tpos_q, qpos_q, iqf_q, dtf_q;
  logic                 tgo_q, qgo_q, start_q;

  pos_t       tp, qp, tp_n, qp_n, iqf_n, dtf_n;
  logic       tg, qg, tgo, qgo, accept, is_snp;
  logic [7:0] tu, qu;
  logic [NUM_CAND-1:0] cand_v;
  rec_t       cand [NUM_CAND];
  bundle_t    bundle;
  logic [1:0] cnt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // First column of an alignment starts from the begin registers.
    tp  = start_q ? PW'(tbeg_q) : tpos_q;
    qp  = start_q ? PW'(qbeg_q) : qpos_q;
    tgo = !start_q && tgo_q;
    qgo = !start_q && qgo_q;
    tg  = (target_char_i == CHAR_GAP);
    qg  = (query_char_i == CHAR_GAP);

    tp_n  = tg ? tp : pos_inc(tp);
    qp_n  = qg ? qp : pos_inc(qp);
    iqf_n = (tg && !tgo) ? qp : iqf_q;
    dtf_n = (qg && !qgo) ? tp : dtf_q;

    tu     = fold_case(target_char_i);
    qu     = fold_case(query_char_i);
    is_snp = !tg && !qg && (tu != CHAR_N) && (qu != CHAR_N) && (tu != qu);

    // Runs closed by a base of this column, and this column's SNP.
    cand_v[0] = tgo && !tg;
    cand[0]   = mk_rec(KIND_INS, to_out(pos_dec(tp)), to_out(pos_dec(tp)),
                       to_out(iqf_q), to_out(pos_dec(qp)));
    cand_v[1] = qgo && !qg;
    cand[1]   = mk_rec(KIND_DEL, to_out(dtf_q), to_out(pos_dec(tp)),
                       to_out(pos_dec(qp)), to_out(pos_dec(qp)));
    cand_v[2] = is_snp;
    cand[2]   = mk_rec(KIND_SNP, to_out(tp), to_out(tp), to_out(qp), to_out(qp));
    // Closed by the end of the alignment.
    cand_v[3] = end_of_alignment_i && tg;
    cand[3]   = mk_rec(KIND_INS, to_out(pos_dec(tp_n)), to_out(pos_dec(tp_n)),
                       to_out(iqf_n), to_out(pos_dec(qp_n)));
    cand_v[4] = end_of_alignment_i && qg;
    cand[4]   = mk_rec(KIND_DEL, to_out(dtf_n), to_out(pos_dec(tp_n)),
                       to_out(pos_dec(qp_n)), to_out(pos_dec(qp_n)));

    // Pack the valid candidates in order; at most three can be set.
    bundle = '0;
    cnt    = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_v[i] && cnt != 2'(MAX_RECORDS)) begin
        bundle.slots[cnt] = cand[i];
        cnt = cnt + 2'd1;
      end
    end
    bundle.count = cnt;
  end

  assign push_o   = accept && (cnt != 2'd0);
  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbeg_q  <= CFG_WIDTH'(1);
      qbeg_q  <= CFG_WIDTH'(1);
      start_q <= 1'b1;
      tgo_q   <= 1'b0;
      qgo_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET_BEGIN: tbeg_q <= cfg_data_i;
          REG_QUERY_BEGIN:  qbeg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        start_q <= end_of_alignment_i;
        tgo_q   <= tg && !end_of_alignment_i;
        qgo_q   <= qg && !end_of_alignment_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tpos_q <= tp_n;
      qpos_q <= qp_n;
      iqf_q  <= iqf_n;
      dtf_q  <= dtf_n;
    end
  end

endmodule

// File: hdl/acv_queue.sv
// Short queue of per-column record bundles between front and back end.
`timescale 1ns / 1ps
module acv_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  acv_pkg::bundle_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output acv_pkg::bundle_t head_o
);
  import acv_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/acv_back.sv
// Back end: unpacks queued bundles into one output record per cycle while out_ready_i is high.
`timescale 1ns / 1ps
module acv_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  acv_pkg::bundle_t               head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     record_kind_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  target_first_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  target_last_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  query_first_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  query_last_o,
  output logic                           final_record_o
);
  import acv_pkg::*;

  logic [1:0] idx_q;
  logic       last_slot, fire;
  rec_t       rec;

  assign rec       = head_i.slots[idx_q];
  assign last_slot = (idx_q == head_i.count - 2'd1);
  assign fire      = out_valid_o && out_ready_i;
  assign pop_o     = fire && last_slot;

  assign out_valid_o    = head_valid_i;
  assign record_kind_o  = rec.kind;
  assign target_first_o = rec.target_first;
  assign target_last_o  = rec.target_last;
  assign query_first_o  = rec.query_first;
  assign query_last_o   = rec.query_last;
  assign final_record_o = last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= last_slot ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// File: hdl/alignment_column_variant_caller.sv
// Top level of the alignment column variant caller.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o): one alignment column per item,
//   target and query character plus end_of_alignment_i on the last column.
//   Output channel (out_valid_o/out_ready_i): one record per item, SNP,
//   insertion or deletion, with final_record_o set on the last record of
//   a column. A column gives zero to three records.
//   Config port: cfg_we_i writes target_begin (index 0) or query_begin
//   (index 1); the new start applies from the first column of the next
//   alignment. Write only while idle.
// Timing:
//   A column's records enter the bundle queue as it is accepted and are
//   offered from its head. One column is taken per cycle while in_ready_o
//   is high; one record is delivered a cycle while out_ready_i is high.
//   A four-entry bundle queue between front and back end absorbs bursts.
// Reset: starts reload to 1, open runs clear, queue empties; the next
//   column begins a new alignment.
// Stall: while out_ready_i is low the record holds; once the queue fills,
//   in_ready_o drops until a bundle drains.
module alignment_column_variant_caller #(
  parameter int unsigned POSITION_WIDTH = acv_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [acv_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     target_char_i,
  input  logic [7:0]                     query_char_i,
  input  logic                           end_of_alignment_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     record_kind_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  target_first_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  target_last_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  query_first_o,
  output logic [acv_pkg::OUT_WIDTH-1:0]  query_last_o,
  output logic                           final_record_o
);
  import acv_pkg::*;

  logic    q_full, q_valid, push, pop;
  bundle_t push_data, head;

  // Front: positions, gap runs, record classification.
  acv_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .target_char_i,
    .query_char_i,
    .end_of_alignment_i,
    .q_full_i (q_full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  // Bundles of records, one per column that produced any.
  acv_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Back: serialize each bundle onto the output channel.
  acv_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .record_kind_o,
    .target_first_o,
    .target_last_o,
    .query_first_o,
    .query_last_o,
    .final_record_o
  );

endmodule

// File: hdl/acv_checker.sv
// Port-level checker for the alignment column variant caller, with its bind.
`timescale 1ns / 1ps
`include "alignment_column_variant_caller_defines.svh"
module acv_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [1:0]                     record_kind_o,
  input logic [acv_pkg::OUT_WIDTH-1:0]  target_first_o,
  input logic [acv_pkg::OUT_WIDTH-1:0]  target_last_o,
  input logic [acv_pkg::OUT_WIDTH-1:0]  query_first_o,
  input logic [acv_pkg::OUT_WIDTH-1:0]  query_last_o,
  input logic                           final_record_o
);
  import acv_pkg::*;

  logic                       out_stall, kind_ok, snp_point_ok, anchor_ok;
  logic [4*OUT_WIDTH+2:0]     out_item;

  assign out_stall    = out_valid_o && !out_ready_i;
  assign out_item     = {record_kind_o, target_first_o, target_last_o,
                         query_first_o, query_last_o, final_record_o};
  assign kind_ok      = (record_kind_o == KIND_SNP) || (record_kind_o == KIND_INS) ||
                        (record_kind_o == KIND_DEL);
  assign snp_point_ok = (record_kind_o != KIND_SNP) ||
                        ((target_first_o == target_last_o) && (query_first_o == query_last_o));
  assign anchor_ok    = ((record_kind_o != KIND_INS) || (target_first_o == target_last_o)) &&
                        ((record_kind_o != KIND_DEL) || (query_first_o == query_last_o));

  // A stalled record keeps its contents.
  `ACV_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_item), "stalled record changed")

  `ACV_ASSERT(a_kind_legal, out_valid_o |-> kind_ok, "illegal record kind")

  `ACV_ASSERT(a_snp_point, out_valid_o |-> snp_point_ok, "SNP span not a single base")

  `ACV_ASSERT(a_indel_anchor, out_valid_o |-> anchor_ok, "indel anchor span wrong")

  // After reset is seen, the queue is empty and no record is offered.
  `ACV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "record offered during reset")

endmodule

bind alignment_column_variant_caller acv_checker u_acv_checker (.*);
